// File: rtl/core/ipse_pkg.sv
package ipse_pkg;

    localparam int MAX_RUN = 48;
    localparam int RUN_CAP = (MAX_RUN < 51) ? MAX_RUN : 51;
    localparam int OFS_W   = 24;
    localparam int LEN_W   = 6;
    localparam int IDX_W   = $clog2(MAX_RUN);

    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_O = 8'h4f;
    localparam logic [7:0] CH_F = 8'h46;

    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             same;
    } t_rec;

    // One request from the front to the back, in emission order:
    // header, record of the run closed before the add, buffer write,
    // record closed after the add, EOF trailer.
    typedef struct packed {
        logic             err;
        logic             hdr;
        logic             ca;
        t_rec             rec_a;
        logic             add;
        logic [IDX_W-1:0] add_idx;
        logic [7:0]       add_byte;
        logic             cb;
        t_rec             rec_b;
        logic             eof;
    } t_cmd;

    function automatic logic [7:0] hdr_char(input logic [LEN_W-1:0] k);
        logic [7:0] c;
        unique case (k)
            LEN_W'(0): c = CH_P;
            LEN_W'(1): c = CH_A;
            LEN_W'(2): c = CH_T;
            LEN_W'(3): c = CH_C;
            default:   c = CH_H;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] eof_char(input logic [LEN_W-1:0] k);
        logic [7:0] c;
        unique case (k)
            LEN_W'(0): c = CH_E;
            LEN_W'(1): c = CH_O;
            default:   c = CH_F;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/ips_patch_stream_encoder_core.sv
// Channel  Direction  Handshake               Payload
// input    in         i_in_valid/o_in_stall   original_byte, modified_byte, tail_only, last_item
// output   out        o_out_valid/i_out_stall out_byte, error, last_of_run
//
// The front classifies one item per cycle into a two-entry request queue while that queue is not full.
// The back sequencer sends one patch byte per cycle from its output register
// while the output is not stalled; it also spends an idle state taking each
// request and an add state writing each run byte into the run buffer.
// Reset is synchronous, active low; the run buffer is not cleared.
// Input stalls only while the request queue is full.
module ips_patch_stream_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_original_byte,
    input  logic [7:0] i_modified_byte,
    input  logic       i_tail_only,
    input  logic       i_last_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_error,
    output logic       o_last_of_run
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    ipse_pkg::t_cmd q_cmd;
    ipse_pkg::t_cmd q_head;

    ipse_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_original_byte(i_original_byte),
        .i_modified_byte(i_modified_byte),
        .i_tail_only    (i_tail_only),
        .i_last_item    (i_last_item),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_cmd        (q_cmd)
    );

    ipse_cmdq u_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (q_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_head (q_head)
    );

    ipse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_error      (o_error),
        .o_last_of_run(o_last_of_run)
    );

`ifndef SYNTHESIS
    a_err_is_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_last_of_run && (o_out_byte == 8'h00))
        else $error("error result must be a lone zero byte");

    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("request popped from empty queue");

    a_push_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("request pushed into full queue");
`endif

endmodule

// File: rtl/core/ipse_front.sv
module ipse_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_original_byte,
    input  logic [7:0]         i_modified_byte,
    input  logic               i_tail_only,
    input  logic               i_last_item,
    input  logic               i_q_full,
    output logic               o_q_push,
    output ipse_pkg::t_cmd     o_q_cmd
);

    logic [ipse_pkg::OFS_W-1:0] r_pos, n_pos;
    logic [ipse_pkg::OFS_W-1:0] r_start, n_start;
    logic [ipse_pkg::LEN_W-1:0] r_len, n_len;
    logic                       r_same, n_same;
    logic [7:0]                 r_first, n_first;
    logic                       r_in_tail, n_in_tail;
    logic                       r_hdr_sent, n_hdr_sent;
    logic                       acc;
    logic                       differ;
    ipse_pkg::t_cmd             cmd;

    assign o_in_stall = i_q_full;
    assign acc        = i_in_valid && !i_q_full;
    assign o_q_push   = acc;
    assign o_q_cmd    = cmd;
    assign differ     = i_tail_only || (i_original_byte != i_modified_byte);

    always_comb begin
        n_pos      = r_pos;
        n_start    = r_start;
        n_len      = r_len;
        n_same     = r_same;
        n_first    = r_first;
        n_in_tail  = r_in_tail;
        n_hdr_sent = r_hdr_sent;
        cmd        = '0;
        if (r_in_tail && !i_tail_only) begin
            cmd.err = 1'b1;
        end else begin
            cmd.hdr    = !r_hdr_sent;
            n_hdr_sent = 1'b1;
            // close the open run at tail entry or on an equal byte
            if ((i_tail_only && !r_in_tail) || !differ) begin
                if (n_len != '0) begin
                    cmd.ca    = 1'b1;
                    cmd.rec_a = '{start: n_start, len: n_len, same: n_same};
                end
                n_len  = '0;
                n_same = 1'b1;
            end
            if (i_tail_only) begin
                n_in_tail = 1'b1;
            end
            if (differ) begin
                if (n_len == '0) begin
                    n_start = r_pos;
                    n_same  = 1'b1;
                    n_first = i_modified_byte;
                end else if (i_modified_byte != r_first) begin
                    n_same = 1'b0;
                end
                cmd.add      = 1'b1;
                cmd.add_idx  = n_len[ipse_pkg::IDX_W-1:0];
                cmd.add_byte = i_modified_byte;
                n_len        = n_len + ipse_pkg::LEN_W'(1);
                if (n_len >= ipse_pkg::LEN_W'(ipse_pkg::RUN_CAP)) begin
                    cmd.cb    = 1'b1;
                    cmd.rec_b = '{start: n_start, len: n_len, same: n_same};
                    n_len     = '0;
                    n_same    = 1'b1;
                end
            end
            n_pos = r_pos + ipse_pkg::OFS_W'(1);
            if (i_last_item) begin
                if (n_len != '0) begin
                    cmd.cb    = 1'b1;
                    cmd.rec_b = '{start: n_start, len: n_len, same: n_same};
                end
                cmd.eof    = 1'b1;
                n_len      = '0;
                n_start    = '0;
                n_same     = 1'b1;
                n_pos      = '0;
                n_in_tail  = 1'b0;
                n_hdr_sent = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_start    <= '0;
            r_len      <= '0;
            r_same     <= 1'b1;
            r_in_tail  <= 1'b0;
            r_hdr_sent <= 1'b0;
        end else if (acc && !cmd.err) begin
            r_pos      <= n_pos;
            r_start    <= n_start;
            r_len      <= n_len;
            r_same     <= n_same;
            r_in_tail  <= n_in_tail;
            r_hdr_sent <= n_hdr_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !cmd.err) begin
            r_first <= n_first;
        end
    end

endmodule

// File: rtl/core/ipse_cmdq.sv
module ipse_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ipse_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ipse_pkg::t_cmd o_head
);

    ipse_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// File: rtl/core/ipse_back.sv
module ipse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  ipse_pkg::t_cmd i_q_head,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_error,
    output logic           o_last_of_run
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HDR  = 4'd1;
    localparam logic [3:0] S_OFS  = 4'd2;
    localparam logic [3:0] S_SIZE = 4'd3;
    localparam logic [3:0] S_DATA = 4'd4;
    localparam logic [3:0] S_RLEB = 4'd5;
    localparam logic [3:0] S_ADD  = 4'd6;
    localparam logic [3:0] S_EOF  = 4'd7;
    localparam logic [3:0] S_ERR  = 4'd8;

    // pending phases of the current request
    localparam int P_HDR = 4;
    localparam int P_CA  = 3;
    localparam int P_ADD = 2;
    localparam int P_CB  = 1;
    localparam int P_EOF = 0;

    logic [3:0]                 r_state, n_state;
    logic [4:0]                 r_pend, n_pend;
    logic                       r_recb, n_recb;
    logic [ipse_pkg::LEN_W-1:0] r_cnt, n_cnt;
    ipse_pkg::t_cmd             r_cmd, n_cmd;
    logic                       r_ov, n_ov;
    logic [7:0]                 r_ob, n_ob;
    logic                       r_oe, n_oe;
    logic                       r_ol, n_ol;

    logic [7:0]                 r_buf [ipse_pkg::MAX_RUN];
    logic [7:0]                 r_rd;
    logic [ipse_pkg::IDX_W-1:0] rd_addr;

    ipse_pkg::t_rec             rec;
    logic                       rle;
    logic                       emitting;
    logic                       out_free;
    logic                       go;
    logic                       fin;
    logic                       rest;
    logic                       pop;
    logic [7:0]                 byte_val;
    logic [ipse_pkg::LEN_W-1:0] len_m1;

    function automatic logic [3:0] pick(input logic [4:0] p);
        logic [3:0] s;
        priority if (p[P_HDR]) s = S_HDR;
        else if (p[P_CA])      s = S_OFS;
        else if (p[P_ADD])     s = S_ADD;
        else if (p[P_CB])      s = S_OFS;
        else if (p[P_EOF])     s = S_EOF;
        else                   s = S_IDLE;
        return s;
    endfunction

    assign rec      = r_recb ? r_cmd.rec_b : r_cmd.rec_a;
    assign rle      = (rec.len > ipse_pkg::LEN_W'(2)) && rec.same;
    assign len_m1   = rec.len - ipse_pkg::LEN_W'(1);
    assign out_free = !r_ov || !i_out_stall;
    assign emitting = (r_state != S_IDLE) && (r_state != S_ADD);
    assign go       = emitting ? out_free : 1'b1;
    assign pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop  = pop;

    always_comb begin
        fin      = 1'b0;
        rest     = 1'b0;
        byte_val = 8'h00;
        unique case (r_state)
            S_HDR: begin
                fin      = (r_cnt == ipse_pkg::LEN_W'(4));
                rest     = r_pend[P_CA] || r_pend[P_CB] || r_pend[P_EOF];
                byte_val = ipse_pkg::hdr_char(r_cnt);
            end
            S_OFS: begin
                rest = 1'b1;
                unique case (r_cnt)
                    ipse_pkg::LEN_W'(0): byte_val = rec.start[23:16];
                    ipse_pkg::LEN_W'(1): byte_val = rec.start[15:8];
                    default:             byte_val = rec.start[7:0];
                endcase
            end
            S_SIZE: begin
                rest = 1'b1;
                if (rle) begin
                    byte_val = (r_cnt == ipse_pkg::LEN_W'(3)) ? 8'(rec.len) : 8'h00;
                end else begin
                    byte_val = (r_cnt == ipse_pkg::LEN_W'(1)) ? 8'(rec.len) : 8'h00;
                end
            end
            S_DATA: begin
                fin      = (r_cnt == len_m1);
                rest     = r_recb ? r_pend[P_EOF] : (r_pend[P_CB] || r_pend[P_EOF]);
                byte_val = r_rd;
            end
            S_RLEB: begin
                fin      = 1'b1;
                rest     = r_recb ? r_pend[P_EOF] : (r_pend[P_CB] || r_pend[P_EOF]);
                byte_val = r_rd;
            end
            S_EOF: begin
                fin      = (r_cnt == ipse_pkg::LEN_W'(2));
                byte_val = ipse_pkg::eof_char(r_cnt);
            end
            S_ERR: begin
                fin = 1'b1;
            end
            S_IDLE, S_ADD: begin
                fin = 1'b1;
            end
            default: begin
                fin = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_recb  = r_recb;
        n_cnt   = r_cnt;
        n_cmd   = r_cmd;
        if (pop) begin
            n_cmd = i_q_head;
            n_cnt = '0;
            if (i_q_head.err) begin
                n_pend  = '0;
                n_state = S_ERR;
            end else begin
                n_pend  = {i_q_head.hdr, i_q_head.ca, i_q_head.add, i_q_head.cb,
                           i_q_head.eof};
                n_state = pick(n_pend);
                n_recb  = !n_pend[P_CA];
            end
        end else if (go && r_state != S_IDLE) begin
            n_cnt = r_cnt + ipse_pkg::LEN_W'(1);
            unique case (r_state)
                S_OFS: begin
                    if (r_cnt == ipse_pkg::LEN_W'(2)) begin
                        n_state = S_SIZE;
                        n_cnt   = '0;
                    end
                end
                S_SIZE: begin
                    if (rle && r_cnt == ipse_pkg::LEN_W'(3)) begin
                        n_state = S_RLEB;
                        n_cnt   = '0;
                    end else if (!rle && r_cnt == ipse_pkg::LEN_W'(1)) begin
                        n_state = S_DATA;
                        n_cnt   = '0;
                    end
                end
                default: begin
                    if (fin) begin
                        unique case (r_state)
                            S_HDR:          n_pend[P_HDR] = 1'b0;
                            S_DATA, S_RLEB: begin
                                if (r_recb) begin
                                    n_pend[P_CB] = 1'b0;
                                end else begin
                                    n_pend[P_CA] = 1'b0;
                                end
                            end
                            S_ADD:          n_pend[P_ADD] = 1'b0;
                            S_EOF:          n_pend[P_EOF] = 1'b0;
                            default:        n_pend = '0;
                        endcase
                        n_state = pick(n_pend);
                        n_recb  = !n_pend[P_CA];
                        n_cnt   = '0;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_ov = r_ov;
        n_ob = r_ob;
        n_oe = r_oe;
        n_ol = r_ol;
        if (out_free) begin
            n_ov = emitting;
            n_ob = byte_val;
            n_oe = (r_state == S_ERR);
            n_ol = fin && !rest;
        end
    end

    // keep the read address one step ahead of the data byte being sent
    always_comb begin
        rd_addr = '0;
        if (r_state == S_DATA) begin
            if (go && !fin) begin
                rd_addr = ipse_pkg::IDX_W'(r_cnt + ipse_pkg::LEN_W'(1));
            end else if (!go) begin
                rd_addr = r_cnt[ipse_pkg::IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD) begin
            r_buf[r_cmd.add_idx] <= r_cmd.add_byte;
        end
        r_rd <= r_buf[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= '0;
            r_recb  <= 1'b0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_recb  <= n_recb;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_ob  <= n_ob;
        r_oe  <= n_oe;
        r_ol  <= n_ol;
    end

    assign o_out_valid   = r_ov;
    assign o_out_byte    = r_ob;
    assign o_error       = r_oe;
    assign o_last_of_run = r_ol;

endmodule
